@@ rtl/rcs_pkg.sv @@
// Shared types and constants for the RGB contrast stretch block.
// No dependencies; imported by rgb_contrast_stretch, rcs_chan, rcs_checker and the testbench.
package rcs_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned DivSteps = 8;
  localparam int unsigned StepW    = 3;
  localparam logic [ChanW-1:0] FullScale = 8'd255;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EMIT = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NOT_RDY  = 1'b1;

  // Register selects on paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             status;
    logic             last;
  } pixel_out_t;

  // One channel's job for the stretch unit
  typedef struct packed {
    logic [ChanW-1:0] value;
    logic [ChanW-1:0] lo;
    logic [ChanW-1:0] hi;
  } chan_req_t;

endpackage

@@ rtl/rgb_contrast_stretch.sv @@
// RGB min-max contrast stretch, top level.
// Depends on rcs_pkg, rcs_ram and rcs_chan.
//
// Load beats (mode 0) write one pixel into the pixel RAM in arrival order and
// widen the per-channel min/max; they give no output beat. Loads past the
// configured pixel count are dropped. Emit beats (mode 1) return one output
// beat each: before the image is complete this is status 1 with zero
// channels; afterwards the next stored pixel is read back, each channel is
// stretched to (v-min)*255/(max-min), rounded down, or passed through
// unchanged when min equals max. An emit runs through a RAM read, a set-up
// step, the bit-serial dividers (one quotient bit per cycle, three channels
// in parallel) and a hand-off to the output register, which waits while that
// register still holds an unaccepted beat; no new beat is taken meanwhile.
// The final pixel carries last and the block then starts a fresh image.
// Image size is set by two APB registers (width at 0x0, height at 0x4),
// each clamped to 1..MAX, at most 255; write them only while the block is
// idle. The pixel RAM has no reset and needs no clearing pass.
module rgb_contrast_stretch
  import rcs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pixel_in_t   in_data_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pixel_out_t  out_data_o,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Effective limits: the size registers are only 8 bits wide
  localparam int unsigned ClampW = (MAX_WIDTH  > 255) ? 255 : MAX_WIDTH;
  localparam int unsigned ClampH = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;
  localparam int unsigned Depth  = ClampW * ClampH;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned PixW   = 3 * ChanW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  function automatic logic [ChanW-1:0] clamp_dim(logic [ChanW-1:0] v,
                                                  logic [ChanW-1:0] lim);
    logic [ChanW-1:0] r;
    r = v;
    if (v == '0) begin
      r = ChanW'(1);
    end else if (v > lim) begin
      r = lim;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [ChanW-1:0] img_w_q, img_h_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {24'd0, (paddr[2] == REG_HEIGHT) ? img_h_q : img_w_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= 8'd128;
      img_h_q <= 8'd128;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        img_w_q <= pwdata[ChanW-1:0];
      end else begin
        img_h_q <= pwdata[ChanW-1:0];
      end
    end
  end

  // pixel count: clamped width times clamped height, never above Depth
  logic [2*ChanW-1:0] prod_w;
  logic [CntW-1:0]    total_w;

  assign prod_w  = clamp_dim(img_w_q, ChanW'(ClampW)) * clamp_dim(img_h_q, ChanW'(ClampH));
  assign total_w = CntW'(prod_w);

  // ---------------------------------------------------------------- control
  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  load_cnt_q, load_cnt_d;
  logic [CntW-1:0]  emit_cnt_q, emit_cnt_d;
  logic [ChanW-1:0] r_min_q, r_min_d, r_max_q, r_max_d;
  logic [ChanW-1:0] g_min_q, g_min_d, g_max_q, g_max_d;
  logic [ChanW-1:0] b_min_q, b_min_d, b_max_q, b_max_d;
  logic             nrdy_q, nrdy_d;
  logic             out_valid_q, out_valid_d;
  pixel_out_t       out_data_q, out_data_d;

  logic             in_acc;
  logic             loaded;
  logic             final_px;
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [PixW-1:0]  ram_rdata;
  logic             chan_start;
  logic [2:0]       chan_done;
  logic [ChanW-1:0] res_r, res_g, res_b;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign loaded     = (load_cnt_q >= total_w);
  assign final_px   = ((emit_cnt_q + CntW'(1)) >= total_w);
  assign chan_start = (state_q == ST_READ);

  assign ram_we   = in_acc && (in_data_i.mode == MODE_LOAD) && !loaded;
  assign ram_addr = (in_data_i.mode == MODE_LOAD) ? load_cnt_q[AddrW-1:0]
                                                  : emit_cnt_q[AddrW-1:0];

  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    emit_cnt_d  = emit_cnt_q;
    r_min_d     = r_min_q;
    r_max_d     = r_max_q;
    g_min_d     = g_min_q;
    g_max_d     = g_max_q;
    b_min_d     = b_min_q;
    b_max_d     = b_max_q;
    nrdy_d      = nrdy_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.mode == MODE_LOAD) begin
            if (!loaded) begin
              load_cnt_d = load_cnt_q + CntW'(1);
              if (in_data_i.red   < r_min_q) r_min_d = in_data_i.red;
              if (in_data_i.red   > r_max_q) r_max_d = in_data_i.red;
              if (in_data_i.green < g_min_q) g_min_d = in_data_i.green;
              if (in_data_i.green > g_max_q) g_max_d = in_data_i.green;
              if (in_data_i.blue  < b_min_q) b_min_d = in_data_i.blue;
              if (in_data_i.blue  > b_max_q) b_max_d = in_data_i.blue;
            end
          end else if (!loaded) begin
            nrdy_d  = 1'b1;
            state_d = ST_DONE;
          end else begin
            // RAM read issued this cycle, data next cycle
            nrdy_d  = 1'b0;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        if (&chan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (nrdy_q) begin
            out_data_d = '{out_red: '0, out_green: '0, out_blue: '0,
                           status: STATUS_NOT_RDY, last: 1'b0};
          end else begin
            out_data_d = '{out_red: res_r, out_green: res_g, out_blue: res_b,
                           status: STATUS_OK, last: final_px};
            if (final_px) begin
              // fresh image
              load_cnt_d = '0;
              emit_cnt_d = '0;
              r_min_d    = FullScale;
              r_max_d    = '0;
              g_min_d    = FullScale;
              g_max_d    = '0;
              b_min_d    = FullScale;
              b_max_d    = '0;
            end else begin
              emit_cnt_d = emit_cnt_q + CntW'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      load_cnt_q  <= '0;
      emit_cnt_q  <= '0;
      r_min_q     <= FullScale;
      r_max_q     <= '0;
      g_min_q     <= FullScale;
      g_max_q     <= '0;
      b_min_q     <= FullScale;
      b_max_q     <= '0;
      nrdy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      emit_cnt_q  <= emit_cnt_d;
      r_min_q     <= r_min_d;
      r_max_q     <= r_max_d;
      g_min_q     <= g_min_d;
      g_max_q     <= g_max_d;
      b_min_q     <= b_min_d;
      b_max_q     <= b_max_d;
      nrdy_q      <= nrdy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload: no reset needed
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------- datapath
  rcs_ram #(
    .Width (PixW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({in_data_i.red, in_data_i.green, in_data_i.blue}),
    .rdata_o (ram_rdata)
  );

  rcs_chan u_chan_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (chan_start),
    .req_i    ('{value: ram_rdata[3*ChanW-1:2*ChanW], lo: r_min_q, hi: r_max_q}),
    .done_o   (chan_done[0]),
    .result_o (res_r)
  );

  rcs_chan u_chan_g (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (chan_start),
    .req_i    ('{value: ram_rdata[2*ChanW-1:ChanW], lo: g_min_q, hi: g_max_q}),
    .done_o   (chan_done[1]),
    .result_o (res_g)
  );

  rcs_chan u_chan_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (chan_start),
    .req_i    ('{value: ram_rdata[ChanW-1:0], lo: b_min_q, hi: b_max_q}),
    .done_o   (chan_done[2]),
    .result_o (res_b)
  );

endmodule

@@ rtl/rcs_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module rcs_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16384,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rcs_chan.sv @@
// One-channel stretch unit: (v-lo)*255/(hi-lo), one quotient bit per cycle.
// Depends on rcs_pkg.
module rcs_chan
  import rcs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  chan_req_t        req_i,
  output logic             done_o,
  output logic [ChanW-1:0] result_o
);

  logic               busy_q, busy_d;
  logic [StepW-1:0]   cnt_q, cnt_d;
  logic               bypass_q, bypass_d;
  logic [ChanW-1:0]   value_q, value_d;
  logic [ChanW-1:0]   span_q, span_d;
  logic [ChanW-1:0]   rem_q, rem_d;
  logic [ChanW-1:0]   nlow_q, nlow_d;
  logic [ChanW-1:0]   quo_q, quo_d;

  logic [ChanW-1:0]   span_w;
  logic [ChanW-1:0]   diff_w;
  logic [2*ChanW-1:0] num_w;
  logic [ChanW:0]     trial_w;
  logic               fits_w;

  // Set-up: clamp the offset into 0..span and scale by 255 as (d<<8)-d
  always_comb begin
    span_w = req_i.hi - req_i.lo;
    diff_w = (req_i.value >= req_i.lo) ? (req_i.value - req_i.lo) : '0;
    if (diff_w > span_w) begin
      diff_w = span_w;
    end
    num_w = {diff_w, {ChanW{1'b0}}} - {{ChanW{1'b0}}, diff_w};
  end

  // Restoring step; the partial remainder stays below span
  assign trial_w = {rem_q, nlow_q[ChanW-1]};
  assign fits_w  = (trial_w >= {1'b0, span_q});

  always_comb begin
    busy_d   = busy_q;
    cnt_d    = cnt_q;
    bypass_d = bypass_q;
    value_d  = value_q;
    span_d   = span_q;
    rem_d    = rem_q;
    nlow_d   = nlow_q;
    quo_d    = quo_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      bypass_d = (req_i.hi <= req_i.lo);
      value_d  = req_i.value;
      span_d   = span_w;
      rem_d    = num_w[2*ChanW-1:ChanW];
      nlow_d   = num_w[ChanW-1:0];
      quo_d    = '0;
    end else if (busy_q) begin
      rem_d  = fits_w ? ChanW'(trial_w - {1'b0, span_q}) : trial_w[ChanW-1:0];
      nlow_d = {nlow_q[ChanW-2:0], 1'b0};
      quo_d  = {quo_q[ChanW-2:0], fits_w};
      cnt_d  = cnt_q + StepW'(1);
      if (cnt_q == StepW'(DivSteps - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bypass_q <= bypass_d;
    value_q  <= value_d;
    span_q   <= span_d;
    rem_q    <= rem_d;
    nlow_q   <= nlow_d;
    quo_q    <= quo_d;
  end

  assign done_o   = busy_q && (cnt_q == StepW'(DivSteps - 1));
  assign result_o = bypass_q ? value_q : quo_q;

endmodule

@@ rtl/rcs_checker.sv @@
// Port-level checks for rgb_contrast_stretch, bound to the top level.
// Depends on rcs_pkg.
module rcs_checker
  import rcs_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input pixel_in_t  in_data_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input pixel_out_t out_data_o,
  input logic       pready
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // not-ready beats carry no pixel and no last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_NOT_RDY) |->
      (out_data_o.out_red == '0) && (out_data_o.out_green == '0) &&
      (out_data_o.out_blue == '0) && !out_data_o.last)
    else $error("not-ready beat with payload");

  // a load beat never raises a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.mode == MODE_LOAD) && !out_valid_o
      |=> !out_valid_o)
    else $error("result beat after a load");

  // after an accepted emit beat the input is not ready in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.mode == MODE_EMIT) |=> !in_ready_o)
    else $error("emit accepted without taking the pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind rgb_contrast_stretch rcs_checker u_rcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rgb_contrast_stretch: drives pixel beats,
// predicts the stretched output beats and compares them field by field.
// Depends on rcs_pkg and the rgb_contrast_stretch RTL.
module testbench;
  import rcs_pkg::*;

  localparam int unsigned MaxWidth     = 128;
  localparam int unsigned MaxHeight    = 128;
  localparam int unsigned StoreDepth   = MaxWidth * MaxHeight;
  // Settle time covers a full emit through the block, with margin.
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned CycleLimit   = 1500000;

  // Clock, reset and DUT ports
  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pixel_in_t   in_data  = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pixel_out_t  out_data;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Stimulus and checking state
  pixel_in_t   pixel_beats_q[$];   // beats waiting for the driver
  pixel_out_t  stretched_q[$];     // output beats still owed by the DUT
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned errors;
  int unsigned cycle_cnt;

  // Shadow copy of the block: config, pixel store, counts, min/max per channel
  logic [7:0]  cfg_width;
  logic [7:0]  cfg_height;
  logic [23:0] px_mem [0:StoreDepth-1];
  int unsigned loaded;
  int unsigned emitted;
  logic [7:0]  chan_lo [3];
  logic [7:0]  chan_hi [3];

  rgb_contrast_stretch #(
    .MAX_WIDTH  (MaxWidth),
    .MAX_HEIGHT (MaxHeight)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------

  function automatic int unsigned clamp_dim(logic [7:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int unsigned pixel_count(logic [7:0] w, logic [7:0] h);
    return clamp_dim(w, MaxWidth) * clamp_dim(h, MaxHeight);
  endfunction

  // Fresh image: counts back to zero, min at full scale, max at zero
  function automatic void clear_image_stats();
    loaded  = 0;
    emitted = 0;
    for (int c = 0; c < 3; c++) begin
      chan_lo[c] = FullScale;
      chan_hi[c] = '0;
    end
  endfunction

  // (v-lo)*255/(hi-lo), floor; a flat channel (lo == hi) passes through
  function automatic logic [7:0] stretch_chan(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
    int unsigned span;
    int unsigned diff;
    if (hi <= lo) return v;
    span = hi - lo;
    diff = (v >= lo) ? v - lo : 0;
    if (diff > span) diff = span;
    return 8'((diff * FullScale) / span);
  endfunction

  // Applies one accepted beat to the shadow state; emits owe one output beat.
  function automatic void predict_stretch(pixel_in_t beat);
    int unsigned total;
    logic [7:0]  ch [3];
    logic [23:0] px;
    pixel_out_t  res;
    total = pixel_count(cfg_width, cfg_height);
    ch[0] = beat.red;
    ch[1] = beat.green;
    ch[2] = beat.blue;
    if (beat.mode == MODE_LOAD) begin
      // loads past the pixel count are dropped, also during readout
      if (loaded < total) begin
        px_mem[loaded] = {ch[0], ch[1], ch[2]};
        loaded++;
        for (int c = 0; c < 3; c++) begin
          if (ch[c] < chan_lo[c]) chan_lo[c] = ch[c];
          if (ch[c] > chan_hi[c]) chan_hi[c] = ch[c];
        end
      end
    end else begin
      res = '0;
      if (loaded < total) begin
        // image incomplete: not-ready beat, zero channels, no state change
        res.status = STATUS_NOT_RDY;
      end else begin
        px            = px_mem[emitted];
        res.out_red   = stretch_chan(px[23:16], chan_lo[0], chan_hi[0]);
        res.out_green = stretch_chan(px[15:8],  chan_lo[1], chan_hi[1]);
        res.out_blue  = stretch_chan(px[7:0],   chan_lo[2], chan_hi[2]);
        res.status    = STATUS_OK;
        res.last      = (emitted + 1 >= total);
        if (res.last) clear_image_stats();
        else emitted++;
      end
      stretched_q.push_back(res);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued beats, gaps at random, holds until accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) predict_stretch(in_data);
      // free to move on unless a beat is still waiting for ready
      if (!in_valid || in_ready) begin
        if (pixel_beats_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_data  <= pixel_beats_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, checks each output beat against the oldest
  // expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_result(pixel_out_t got);
    pixel_out_t want;
    if (stretched_q.size() == 0) begin
      errors++;
      $display("%0t: output beat with nothing expected, expected none, actual %h",
               $time, got);
      return;
    end
    want = stretched_q.pop_front();
    check_field("out_red",   want.out_red,   got.out_red);
    check_field("out_green", want.out_green, got.out_green);
    check_field("out_blue",  want.out_blue,  got.out_blue);
    check_field("status",    {7'b0, want.status}, {7'b0, got.status});
    check_field("last",      {7'b0, want.last},   {7'b0, got.last});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pixel_in_t make_beat(logic mode, logic [7:0] r, logic [7:0] g,
                                          logic [7:0] b);
    pixel_in_t beat;
    beat.mode  = mode;
    beat.red   = r;
    beat.green = g;
    beat.blue  = b;
    return beat;
  endfunction

  function automatic pixel_in_t random_beat(logic mode);
    return make_beat(mode, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
  endfunction

  function automatic logic [7:0] chan_val(int unsigned base, int unsigned spread);
    int unsigned v;
    v = base + $urandom_range(spread);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Queues one whole image: all loads then all emits. Some images get noise:
  // early emits among the loads and surplus loads before and among the emits.
  // Nothing lands after the final emit, so the image always completes.
  function automatic int queue_image(int unsigned total);
    int unsigned base [3];
    int unsigned spread [3];
    int unsigned kind;
    bit          noisy;
    int          pushed;
    noisy  = ($urandom_range(9) < 3);
    pushed = 0;
    // per channel: full range, narrow band or flat
    for (int c = 0; c < 3; c++) begin
      kind = $urandom_range(9);
      if (kind < 5) begin
        base[c]   = 0;
        spread[c] = 255;
      end else if (kind < 8) begin
        base[c]   = $urandom_range(255);
        spread[c] = $urandom_range(1, 20);
      end else begin
        base[c]   = $urandom_range(255);
        spread[c] = 0;
      end
    end
    for (int unsigned i = 0; i < total; i++) begin
      if (noisy && $urandom_range(19) == 0) begin
        pixel_beats_q.push_back(random_beat(MODE_EMIT));
        pushed++;
      end
      pixel_beats_q.push_back(make_beat(MODE_LOAD, chan_val(base[0], spread[0]),
                                        chan_val(base[1], spread[1]),
                                        chan_val(base[2], spread[2])));
      pushed++;
    end
    if (noisy) begin
      repeat ($urandom_range(0, 3)) begin
        pixel_beats_q.push_back(random_beat(MODE_LOAD));
        pushed++;
      end
    end
    for (int unsigned i = 0; i < total; i++) begin
      if (noisy && $urandom_range(19) == 0) begin
        pixel_beats_q.push_back(random_beat(MODE_LOAD));
        pushed++;
      end
      pixel_beats_q.push_back(random_beat(MODE_EMIT));
      pushed++;
    end
    return pushed;
  endfunction

  // Mostly small dimensions, now and then 0, 128 or something that clamps
  function automatic logic [7:0] pick_dim();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd128;
    if (r == 2) return 8'($urandom_range(129, 255));
    return 8'($urandom_range(1, 8));
  endfunction

  // Sender pause: nothing queued, nothing on the bus, every result back,
  // then the settle time so a trailing load has surely retired.
  task automatic drain_and_settle();
    while (pixel_beats_q.size() != 0 || in_valid || stretched_q.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic write_reg(logic sel, logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {sel, 2'b00};
    pwdata  <= {24'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_WIDTH) cfg_width = value;
    else cfg_height = value;
  endtask

  task automatic set_size(logic [7:0] w, logic [7:0] h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // Random phase: new size, a few images, repeat until the beat budget is used
  task automatic run_phase(int budget);
    int          queued;
    logic [7:0]  w;
    logic [7:0]  h;
    int unsigned total;
    queued = 0;
    while (queued < budget) begin
      drain_and_settle();
      w = pick_dim();
      h = pick_dim();
      // keep images small: one long side pairs with a very short one
      if (clamp_dim(w, MaxWidth) > 8) h = 8'($urandom_range(0, 2));
      else if (clamp_dim(h, MaxHeight) > 8) w = 8'($urandom_range(0, 2));
      set_size(w, h);
      total = pixel_count(w, h);
      repeat ((total > 64) ? 1 : $urandom_range(1, 3)) queued += queue_image(total);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    sender_idle_pct   = 28;
    receiver_idle_pct = 51;
    errors            = 0;
    cycle_cnt         = 0;
    cfg_width         = 8'd128;
    cfg_height        = 8'd128;
    clear_image_stats();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero registers act as 1: single-pixel image. Early emit is not ready,
    // a surplus load is dropped, the one pixel passes through with last.
    set_size(8'd0, 8'd0);
    pixel_beats_q.push_back(random_beat(MODE_EMIT));
    pixel_beats_q.push_back(make_beat(MODE_LOAD, 8'd255, 8'd0, 8'd128));
    pixel_beats_q.push_back(make_beat(MODE_LOAD, 8'd7, 8'd7, 8'd7));
    pixel_beats_q.push_back(make_beat(MODE_EMIT, 8'd0, 8'd0, 8'd0));
    drain_and_settle();

    // 3x1: full-range red and green, flat blue, a load dropped mid-readout
    set_size(8'd3, 8'd1);
    pixel_beats_q.push_back(make_beat(MODE_LOAD, 8'd0, 8'd255, 8'd7));
    pixel_beats_q.push_back(make_beat(MODE_LOAD, 8'd255, 8'd0, 8'd7));
    pixel_beats_q.push_back(make_beat(MODE_LOAD, 8'd128, 8'd128, 8'd7));
    pixel_beats_q.push_back(make_beat(MODE_EMIT, 8'd255, 8'd255, 8'd255));
    pixel_beats_q.push_back(make_beat(MODE_LOAD, 8'd1, 8'd2, 8'd3));
    pixel_beats_q.push_back(random_beat(MODE_EMIT));
    pixel_beats_q.push_back(random_beat(MODE_EMIT));
    drain_and_settle();

    // 1x2: red with a span of one, early emits before and between the loads
    set_size(8'd1, 8'd2);
    pixel_beats_q.push_back(random_beat(MODE_EMIT));
    pixel_beats_q.push_back(make_beat(MODE_LOAD, 8'd10, 8'd20, 8'd30));
    pixel_beats_q.push_back(random_beat(MODE_EMIT));
    pixel_beats_q.push_back(make_beat(MODE_LOAD, 8'd11, 8'd200, 8'd30));
    pixel_beats_q.push_back(random_beat(MODE_EMIT));
    pixel_beats_q.push_back(random_beat(MODE_EMIT));

    run_phase(600);

    drain_and_settle();
    sender_idle_pct   = 51;
    receiver_idle_pct = 28;
    run_phase(600);

    drain_and_settle();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    run_phase(200);

    drain_and_settle();
    if (errors == 0) begin
      $display("PASS rgb_contrast_stretch");
    end else begin
      $display("FAIL rgb_contrast_stretch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("FAIL rgb_contrast_stretch");
    $finish;
  end

endmodule
